// ===== rtl/fagd_pkg.sv =====
// ----------------------------------------------------------------------------
// fagd_pkg - shared definitions for the anisotropy gradient derivative core
// Fixed-point format, configuration register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package fagd_pkg;

    // Fraction bits of every fixed-point value.
    localparam int FRAC_BITS = 24;

    // Datapath word for intermediate products.
    typedef logic signed [63:0] q_t;

    localparam int CFG_W = 31;
    localparam int IDX_W = 2;
    localparam int GRAD_W = 32;

    // Quotient width: w never exceeds one.
    localparam int W_W = FRAC_BITS + 1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_DELTA = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_GAMMA = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_EPS   = IDX_W'(2);

    localparam logic [CFG_W-1:0] DELTA_RST = CFG_W'(335544);
    localparam logic [CFG_W-1:0] GAMMA_RST = CFG_W'(16777216);
    localparam logic [CFG_W-1:0] EPS_RST   = CFG_W'(16777216);

    localparam q_t Q_ONE = q_t'(64'd1 << FRAC_BITS);

    // Latency of one fixed-point multiply unit.
    localparam int QMUL_LAT = 2;

    // Squares, divider setup, one stage per quotient bit, then the product chain.
    localparam int LANE_LAT = FRAC_BITS + 12;

endpackage

// ===== rtl/fagd_qmul.sv =====
// ----------------------------------------------------------------------------
// fagd_qmul - pipelined saturating fixed-point multiply
// Sign-magnitude product from four 32x32 partial products, truncated toward
// zero by FRAC_BITS and saturated to the largest 64-bit magnitude.
// ----------------------------------------------------------------------------
module fagd_qmul (
    input  logic          clk,
    input  logic          en,
    input  fagd_pkg::q_t  x,
    input  fagd_pkg::q_t  y,
    output fagd_pkg::q_t  p
);

    logic [63:0]  ux;
    logic [63:0]  uy;
    logic [63:0]  pp00;
    logic [63:0]  pp01;
    logic [63:0]  pp10;
    logic [63:0]  pp11;
    logic         neg_reg;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [63:0]  mid;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  r;
    logic [63:0]  mag;
    logic         sat;
    fagd_pkg::q_t p_next;
    fagd_pkg::q_t p_reg;

    always_comb
    begin
        ux   = x[63] ? (64'd0 - 64'(x)) : 64'(x);
        uy   = y[63] ? (64'd0 - 64'(y)) : 64'(y);
        pp00 = 64'(ux[31:0]) * 64'(uy[31:0]);
        pp01 = 64'(ux[31:0]) * 64'(uy[63:32]);
        pp10 = 64'(ux[63:32]) * 64'(uy[31:0]);
        pp11 = 64'(ux[63:32]) * 64'(uy[63:32]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= x[63] ^ y[63];
            p00_reg <= pp00;
            p01_reg <= pp01;
            p10_reg <= pp10;
            p11_reg <= pp11;
        end
    end

    // Combine partial products, drop the fraction, saturate.
    always_comb
    begin
        mid = {32'd0, p00_reg[63:32]} + {32'd0, p01_reg[31:0]} + {32'd0, p10_reg[31:0]};
        lo  = {mid[31:0], p00_reg[31:0]};
        hi  = p11_reg + {32'd0, p01_reg[63:32]} + {32'd0, p10_reg[63:32]}
              + {32'd0, mid[63:32]};
        r   = (hi << (64 - fagd_pkg::FRAC_BITS)) | (lo >> fagd_pkg::FRAC_BITS);
        sat = ((hi >> fagd_pkg::FRAC_BITS) != 64'd0) || r[63];
        mag = sat ? 64'h7FFF_FFFF_FFFF_FFFF : r;
        p_next = neg_reg ? fagd_pkg::q_t'(64'd0 - mag) : fagd_pkg::q_t'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/fagd_lane.sv =====
// ----------------------------------------------------------------------------
// fagd_lane - derivative pipeline for one axis
// Squares, a restoring divider with one quotient bit per stage, then the
// anisotropy product chain and the final clamp.
// ----------------------------------------------------------------------------
module fagd_lane (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [fagd_pkg::GRAD_W-1:0]  g_in,
    input  logic signed [fagd_pkg::GRAD_W-1:0]  o_in,
    input  logic [fagd_pkg::CFG_W-1:0]          delta,
    input  fagd_pkg::q_t                        ge,
    output logic signed [fagd_pkg::GRAD_W-1:0]  deriv
);

    localparam int F = fagd_pkg::FRAC_BITS;

    logic [31:0]                         ug;
    logic [31:0]                         uo;
    logic [63:0]                         sqg_reg;
    logic [63:0]                         sqo_reg;
    logic signed [fagd_pkg::GRAD_W-1:0]  ga_reg;
    logic [63:0]                         dsum;

    logic [63:0]                         dv_d[F+1];
    logic [63:0]                         dv_rem[F+1];
    logic [fagd_pkg::W_W-1:0]            dv_w[F+1];
    logic signed [fagd_pkg::GRAD_W-1:0]  dv_g[F+1];
    logic [63:0]                         st_rem[F];
    logic [fagd_pkg::W_W-1:0]            st_w[F];

    fagd_pkg::q_t                        wi;
    fagd_pkg::q_t                        om;
    fagd_pkg::q_t                        x2;
    fagd_pkg::q_t                        q1;
    fagd_pkg::q_t                        cq;
    logic signed [fagd_pkg::GRAD_W-1:0]  gq_reg[fagd_pkg::QMUL_LAT];
    fagd_pkg::q_t                        delta_q;
    fagd_pkg::q_t                        q2;
    fagd_pkg::q_t                        q3;
    fagd_pkg::q_t                        t1;
    fagd_pkg::q_t                        a_next;
    fagd_pkg::q_t                        a_reg;
    fagd_pkg::q_t                        b_reg;
    fagd_pkg::q_t                        t1_reg;
    fagd_pkg::q_t                        t2;
    fagd_pkg::q_t                        bp_reg[fagd_pkg::QMUL_LAT];
    fagd_pkg::q_t                        t3;
    fagd_pkg::q_t                        tc;
    fagd_pkg::q_t                        td;
    logic signed [fagd_pkg::GRAD_W-1:0]  deriv_next;
    logic signed [fagd_pkg::GRAD_W-1:0]  deriv_reg;

    // Squares of the magnitudes.
    always_comb
    begin
        ug = g_in[31] ? (32'd0 - 32'(g_in)) : 32'(g_in);
        uo = o_in[31] ? (32'd0 - 32'(o_in)) : 32'(o_in);
        dsum = sqg_reg + sqo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqg_reg <= 64'(ug) * 64'(ug);
            sqo_reg <= 64'(uo) * 64'(uo);
            ga_reg  <= g_in;
        end
    end

    // One restoring step per stage.
    always_comb
    begin
        for (int k = 0; k < F; k++)
        begin
            if (dv_rem[k] >= (dv_d[k] - dv_rem[k]))
            begin
                st_w[k]   = {dv_w[k][fagd_pkg::W_W-2:0], 1'b1};
                st_rem[k] = dv_rem[k] - (dv_d[k] - dv_rem[k]);
            end
            else
            begin
                st_w[k]   = {dv_w[k][fagd_pkg::W_W-2:0], 1'b0};
                st_rem[k] = dv_rem[k] << 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_d[0] <= dsum;
            dv_g[0] <= ga_reg;
            if (sqg_reg >= dsum)
            begin
                dv_w[0]   <= fagd_pkg::W_W'(1);
                dv_rem[0] <= sqg_reg - dsum;
            end
            else
            begin
                dv_w[0]   <= '0;
                dv_rem[0] <= sqg_reg;
            end
            for (int k = 0; k < F; k++)
            begin
                dv_d[k+1]   <= dv_d[k];
                dv_g[k+1]   <= dv_g[k];
                dv_w[k+1]   <= st_w[k];
                dv_rem[k+1] <= st_rem[k];
            end
        end
    end

    // w(1-w) and (1-w)(2w-1).
    always_comb
    begin
        wi = fagd_pkg::q_t'(64'(dv_w[F]));
        om = fagd_pkg::Q_ONE - wi;
        x2 = (wi <<< 1) - fagd_pkg::Q_ONE;
        delta_q = fagd_pkg::q_t'(64'(delta));
    end

    fagd_qmul u_wom (.clk(clk), .en(en), .x(wi), .y(om), .p(q1));
    fagd_qmul u_omx (.clk(clk), .en(en), .x(om), .y(x2), .p(cq));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gq_reg[0] <= dv_g[F];
            for (int k = 1; k < fagd_pkg::QMUL_LAT; k++)
            begin
                gq_reg[k] <= gq_reg[k-1];
            end
        end
    end

    fagd_qmul u_dw (.clk(clk), .en(en), .x(delta_q), .y(q1), .p(q2));
    fagd_qmul u_dc (.clk(clk), .en(en), .x(delta_q), .y(cq), .p(q3));
    fagd_qmul u_gg (.clk(clk), .en(en), .x(ge),
                    .y(fagd_pkg::q_t'(gq_reg[fagd_pkg::QMUL_LAT-1])), .p(t1));

    // Anisotropy factor a and bracket b.
    always_comb
    begin
        a_next = fagd_pkg::Q_ONE + delta_q - (q2 <<< 3);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a_next;
            b_reg  <= a_next + (q3 <<< 4);
            t1_reg <= t1;
            bp_reg[0] <= b_reg;
            for (int k = 1; k < fagd_pkg::QMUL_LAT; k++)
            begin
                bp_reg[k] <= bp_reg[k-1];
            end
        end
    end

    fagd_qmul u_ta (.clk(clk), .en(en), .x(t1_reg), .y(a_reg), .p(t2));
    fagd_qmul u_tb (.clk(clk), .en(en), .x(t2), .y(bp_reg[fagd_pkg::QMUL_LAT-1]), .p(t3));

    // Clamp, double, saturate to 32 bits.
    always_comb
    begin
        if (t3 > fagd_pkg::q_t'(64'sd2147483648))
        begin
            tc = fagd_pkg::q_t'(64'sd2147483648);
        end
        else if (t3 < fagd_pkg::q_t'(-64'sd2147483648))
        begin
            tc = fagd_pkg::q_t'(-64'sd2147483648);
        end
        else
        begin
            tc = t3;
        end
        td = tc <<< 1;
        if (td > fagd_pkg::q_t'(64'sd2147483647))
        begin
            deriv_next = 32'sh7FFF_FFFF;
        end
        else if (td < fagd_pkg::q_t'(-64'sd2147483648))
        begin
            deriv_next = 32'sh8000_0000;
        end
        else
        begin
            deriv_next = td[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deriv_reg <= deriv_next;
        end
    end

    assign deriv = deriv_reg;

endmodule

// ===== rtl/fourfold_anisotropy_gradient_derivative_core.sv =====
// ----------------------------------------------------------------------------
// fourfold_anisotropy_gradient_derivative_core - phase-field anisotropy derivative
// One request carries the staggered and central gradients of one lattice
// point; two identical lanes compute the x and y derivatives side by side and
// their results leave together as one result. The pipeline takes one request
// per clock while in_ready is high. Each request passes through the squares
// and the divider setup, the stages of the restoring divider, one per quotient
// bit, that form w = g^2/(g^2+o^2), and the chain of saturating multiplies and
// the final clamp. The whole pipeline advances together and holds only while
// a finished result is waiting at the output and out_ready is low. The product
// gamma*eps is formed continuously from the configuration registers; write them
// only while no request is in flight. Register indexes: 0 delta, 1 gamma,
// 2 epsilon; other indexes are dropped.
// ----------------------------------------------------------------------------
module fourfold_anisotropy_gradient_derivative_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fagd_pkg::GRAD_W-1:0]  stag_grad_x,
    input  logic signed [fagd_pkg::GRAD_W-1:0]  stag_grad_y,
    input  logic signed [fagd_pkg::GRAD_W-1:0]  cent_grad_x,
    input  logic signed [fagd_pkg::GRAD_W-1:0]  cent_grad_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fagd_pkg::GRAD_W-1:0]  deriv_x,
    output logic signed [fagd_pkg::GRAD_W-1:0]  deriv_y,
    input  logic                                cfg_wr_en,
    input  logic [fagd_pkg::IDX_W-1:0]          cfg_index,
    input  logic [fagd_pkg::CFG_W-1:0]          cfg_data
);

    logic [fagd_pkg::CFG_W-1:0]     delta_reg;
    logic [fagd_pkg::CFG_W-1:0]     gamma_reg;
    logic [fagd_pkg::CFG_W-1:0]     eps_reg;
    logic [fagd_pkg::LANE_LAT-1:0]  vld_reg;
    logic [fagd_pkg::LANE_LAT-1:0]  vld_next;
    logic                           adv;
    fagd_pkg::q_t                   ge;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= fagd_pkg::DELTA_RST;
            gamma_reg <= fagd_pkg::GAMMA_RST;
            eps_reg   <= fagd_pkg::EPS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fagd_pkg::REG_DELTA: delta_reg <= cfg_data;
                fagd_pkg::REG_GAMMA: gamma_reg <= cfg_data;
                fagd_pkg::REG_EPS:   eps_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance everything unless the finished result is still held.
    assign adv      = !vld_reg[fagd_pkg::LANE_LAT-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[fagd_pkg::LANE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // gamma * epsilon, shared by both lanes.
    fagd_qmul u_ge (
        .clk (clk),
        .en  (1'b1),
        .x   (fagd_pkg::q_t'(64'(gamma_reg))),
        .y   (fagd_pkg::q_t'(64'(eps_reg))),
        .p   (ge)
    );

    // x pairs its staggered gradient with central y, and y with central x.
    fagd_lane u_lane_x (
        .clk   (clk),
        .en    (adv),
        .g_in  (stag_grad_x),
        .o_in  (cent_grad_y),
        .delta (delta_reg),
        .ge    (ge),
        .deriv (deriv_x)
    );

    fagd_lane u_lane_y (
        .clk   (clk),
        .en    (adv),
        .g_in  (stag_grad_y),
        .o_in  (cent_grad_x),
        .delta (delta_reg),
        .ge    (ge),
        .deriv (deriv_y)
    );

    assign out_valid = vld_reg[fagd_pkg::LANE_LAT-1];

    // A stall must freeze the valid pipeline.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid pipeline moved during stall");

    // An accepted request enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted request not in first stage");

    // Results are doubled, so odd only at positive saturation.
    a_even_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (deriv_x[0] == 1'b0) || (deriv_x == 32'sh7FFF_FFFF))
        else $error("deriv_x odd without saturation");

    a_even_y: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (deriv_y[0] == 1'b0) || (deriv_y == 32'sh7FFF_FFFF))
        else $error("deriv_y odd without saturation");

    // Zero surface energy gives zero derivatives.
    a_zero_gamma: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gamma_reg == '0) |-> (deriv_x == '0) && (deriv_y == '0))
        else $error("nonzero derivative with zero gamma");

endmodule
